FILE: sv/sdb_pkg.sv
package sdb_pkg;

	// Word and byte geometry
	localparam int WORD_BITS = 16;
	localparam int BYTE_BITS = 8;

	// Event kinds carried on the command field
	localparam logic [1:0] EV_XFER   = 2'd0;
	localparam logic [1:0] EV_SELECT = 2'd1;
	localparam logic [1:0] EV_RESET  = 2'd2;

	// Command word decode
	localparam logic [WORD_BITS-1:0] OPC_MASK     = 16'hF000;
	localparam logic [WORD_BITS-1:0] OPC_LCD_CMD  = 16'h3000;
	localparam logic [WORD_BITS-1:0] OPC_LCD_DATA = 16'h1000;
	localparam logic [WORD_BITS-1:0] OPC_BYPASS   = 16'hD000;
	localparam logic [WORD_BITS-1:0] OPC_NOP      = 16'h8000;
	localparam logic [WORD_BITS-1:0] OPC_REG_RD   = 16'h4000;
	localparam logic [WORD_BITS-1:0] OPC_REG_WR   = 16'h0000;

	// ID table
	localparam logic [WORD_BITS-1:0] ID_ADDR_0 = 16'h0000;
	localparam logic [WORD_BITS-1:0] ID_ADDR_1 = 16'h0014;
	localparam logic [WORD_BITS-1:0] ID_ADDR_2 = 16'h0202;
	localparam logic [WORD_BITS-1:0] ID_VAL_0  = 16'h706B;
	localparam logic [WORD_BITS-1:0] ID_VAL_1  = 16'h04D1;
	localparam logic [WORD_BITS-1:0] ID_VAL_2  = 16'h0000;

	typedef struct packed {
		logic [1:0]           command;
		logic [BYTE_BITS-1:0] byte_in;
		logic                 sa0_level;
		logic [BYTE_BITS-1:0] lcd_reply;
	} in_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] byte_out;
		logic                 lcd_valid;
		logic [BYTE_BITS-1:0] lcd_byte;
		logic                 frame_line;
		logic                 stray_data;
	} out_t;

	// Read-back value of the ID registers
	function automatic logic [WORD_BITS-1:0] table_value(input logic [WORD_BITS-1:0] addr);
		logic [WORD_BITS-1:0] v;
		case (addr)
			ID_ADDR_0: v = ID_VAL_0;
			ID_ADDR_1: v = ID_VAL_1;
			ID_ADDR_2: v = ID_VAL_2;
			default:   v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/spi_display_bridge_command_port_top.sv
// Channel | Direction | Valid     | Stall     | Payload
// in      | to block  | in_valid  | in_stall  | in_data  (sdb_pkg::in_t)
// out     | from block| out_valid | out_stall | out_data (sdb_pkg::out_t)
//
// One transaction a cycle unless out_stall holds; input register, then result register.
// Each event is decoded against the port state in the cycle it leaves the input register.
// arst_n low clears all control state and both valid flags; payloads are not reset.
// A stalled output holds the result register and the input register behind it;
// in_stall rises only when the input register is full and cannot advance.
module spi_display_bridge_command_port_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  sdb_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output sdb_pkg::out_t out_data
);
	import sdb_pkg::*;

	typedef enum logic [1:0] {STEP_IDLE, STEP_ADDR, STEP_VALUE} step_t;

	logic                 valid_s1;
	in_t                  in_s1;
	logic                 out_valid_q;
	out_t                 out_q;
	logic                 adv;

	// Port state
	logic                 cmd_mode_q, cmd_mode_d;
	logic                 bypass_q, bypass_d;
	logic                 second_q, second_d;
	logic [BYTE_BITS-1:0] req_high_q, req_high_d;
	logic [WORD_BITS-1:0] reply_q, reply_d;
	step_t                step_q, step_d;
	logic                 is_read_q, is_read_d;
	logic [WORD_BITS-1:0] reg_addr_q, reg_addr_d;

	out_t                 res;
	logic [WORD_BITS-1:0] word;

	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Event decode and state update
	always_comb begin
		cmd_mode_d = cmd_mode_q;
		bypass_d   = bypass_q;
		second_d   = second_q;
		req_high_d = req_high_q;
		reply_d    = reply_q;
		step_d     = step_q;
		is_read_d  = is_read_q;
		reg_addr_d = reg_addr_q;
		res        = '0;
		word       = {req_high_q, in_s1.byte_in};
		case (in_s1.command)
			EV_XFER: begin
				if (!cmd_mode_q && bypass_q) begin
					res.byte_out  = in_s1.lcd_reply;
					res.lcd_valid = 1'b1;
					res.lcd_byte  = in_s1.byte_in;
				end else if (!second_q) begin
					res.byte_out = reply_q[WORD_BITS-1 -: BYTE_BITS];
					req_high_d   = in_s1.byte_in;
					second_d     = 1'b1;
				end else begin
					res.byte_out = reply_q[BYTE_BITS-1:0];
					second_d     = 1'b0;
					req_high_d   = '0;
					reply_d      = '0;
					if (cmd_mode_q) begin
						bypass_d = 1'b0;
						if ((word & OPC_MASK) == OPC_LCD_CMD) begin
							res.lcd_valid  = 1'b1;
							res.lcd_byte   = word[11:4];
							res.frame_line = 1'b1;
							reply_d        = {{(WORD_BITS-BYTE_BITS){1'b0}}, in_s1.lcd_reply};
							step_d         = STEP_IDLE;
						end else if ((word & OPC_MASK) == OPC_LCD_DATA) begin
							res.lcd_valid = 1'b1;
							res.lcd_byte  = word[11:4];
							reply_d       = {{(WORD_BITS-BYTE_BITS){1'b0}}, in_s1.lcd_reply};
							step_d        = STEP_IDLE;
						end else if (word == OPC_REG_WR) begin
							is_read_d = 1'b0;
							step_d    = STEP_ADDR;
						end else if (word == OPC_REG_RD) begin
							is_read_d = 1'b1;
							step_d    = STEP_ADDR;
						end else if (word == OPC_BYPASS) begin
							bypass_d = 1'b1;
						end else if (word == OPC_NOP) begin
							step_d = STEP_IDLE;
						end
					end else begin
						case (step_q)
							STEP_IDLE: res.stray_data = 1'b1;
							STEP_ADDR: begin
								reg_addr_d = word;
								step_d     = STEP_VALUE;
							end
							default: begin
								if (is_read_q)
									reply_d = table_value(reg_addr_q);
								step_d = STEP_IDLE;
							end
						endcase
					end
				end
			end
			EV_SELECT: begin
				// Only a real change of level drops the half word
				if (!in_s1.sa0_level != cmd_mode_q) begin
					cmd_mode_d = !in_s1.sa0_level;
					second_d   = 1'b0;
					req_high_d = '0;
					if (!in_s1.sa0_level)
						bypass_d = 1'b0;
				end
			end
			EV_RESET: begin
				step_d     = STEP_IDLE;
				second_d   = 1'b0;
				req_high_d = '0;
				reply_d    = '0;
				bypass_d   = 1'b0;
			end
			default: ;
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// Result register and port state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cmd_mode_q  <= 1'b0;
			bypass_q    <= 1'b0;
			second_q    <= 1'b0;
			req_high_q  <= '0;
			reply_q     <= '0;
			step_q      <= STEP_IDLE;
			is_read_q   <= 1'b0;
			reg_addr_q  <= '0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				cmd_mode_q <= cmd_mode_d;
				bypass_q   <= bypass_d;
				second_q   <= second_d;
				req_high_q <= req_high_d;
				reply_q    <= reply_d;
				step_q     <= step_d;
				is_read_q  <= is_read_d;
				reg_addr_q <= reg_addr_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_q <= res;
		end
	end

	// Frame line only ever accompanies a forwarded byte
	a_frame_with_lcd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_q.frame_line || out_q.lcd_valid))
		else $error("frame_line without lcd_valid");

	// A stray word never forwards anything
	a_stray_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.stray_data && out_q.lcd_valid))
		else $error("stray_data together with lcd_valid");

	// Active bypass in data mode never holds a half word
	a_bypass_no_half: assert property (@(posedge clk) disable iff (!arst_n)
		(bypass_q && !cmd_mode_q) |-> !second_q)
		else $error("half word held during bypass");

	// Stalled output keeps the input register from moving on
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && valid_s1) |-> in_stall)
		else $error("input register not held under output stall");

endmodule

FILE: verif/spi_display_bridge_command_port_checker.sv
module spi_display_bridge_command_port_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  sdb_pkg::in_t   in_data,
	input  logic           out_valid,
	input  logic           out_stall,
	input  sdb_pkg::out_t  out_data,
	input  logic           end_check,
	output int             outstanding,
	output int             fail_count,
	output int             results_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	import sdb_pkg::*;

	// Position in a register access sequence
	typedef enum logic [1:0] {
		STEP_IDLE  = 2'd0,
		STEP_ADDR  = 2'd1,
		STEP_VALUE = 2'd2
	} seq_step_e;

	// Shadow copy of the port state
	logic                 port_cmd_mode;
	logic                 port_bypass;
	logic                 hi_held;
	logic [BYTE_BITS-1:0] hi_byte;
	logic [WORD_BITS-1:0] shift_word;
	logic [1:0]           seq_step;
	logic                 rd_pending;
	logic [WORD_BITS-1:0] reg_addr;

	out_t pending_results[$];
	int   n_fail    = 0;
	int   n_checked = 0;
	logic end_seen  = 1'b0;

	assign fail_count      = n_fail;
	assign results_checked = n_checked;

	// ID registers as seen by a read
	function automatic logic [WORD_BITS-1:0] id_lookup(input logic [WORD_BITS-1:0] addr);
		if (addr == ID_ADDR_0)
			return ID_VAL_0;
		if (addr == ID_ADDR_1)
			return ID_VAL_1;
		if (addr == ID_ADDR_2)
			return ID_VAL_2;
		return '0;
	endfunction

	// Works out the result of one event and advances the shadow state
	task automatic predict_bridge_event(input in_t ev, output out_t res);
		logic [WORD_BITS-1:0] w;
		logic [WORD_BITS-1:0] nxt;
		res = '0;
		case (ev.command)
			EV_XFER: begin
				if (!port_cmd_mode && port_bypass) begin
					// bypass: byte straight through, LCD answer straight back
					res.byte_out  = ev.lcd_reply;
					res.lcd_valid = 1'b1;
					res.lcd_byte  = ev.byte_in;
				end else if (!hi_held) begin
					res.byte_out = shift_word[WORD_BITS-1 -: BYTE_BITS];
					hi_byte      = ev.byte_in;
					hi_held      = 1'b1;
				end else begin
					res.byte_out = shift_word[BYTE_BITS-1:0];
					w            = {hi_byte, ev.byte_in};
					hi_held      = 1'b0;
					hi_byte      = '0;
					nxt          = '0;
					if (port_cmd_mode) begin
						// any command word other than the bypass command ends bypass
						port_bypass = 1'b0;
						if ((w & OPC_MASK) == OPC_LCD_CMD) begin
							res.lcd_valid  = 1'b1;
							res.lcd_byte   = w[11:4];
							res.frame_line = 1'b1;
							nxt            = {{(WORD_BITS-BYTE_BITS){1'b0}}, ev.lcd_reply};
							seq_step       = STEP_IDLE;
						end else if ((w & OPC_MASK) == OPC_LCD_DATA) begin
							res.lcd_valid = 1'b1;
							res.lcd_byte  = w[11:4];
							nxt           = {{(WORD_BITS-BYTE_BITS){1'b0}}, ev.lcd_reply};
							seq_step      = STEP_IDLE;
						end else if (w == OPC_REG_WR) begin
							rd_pending = 1'b0;
							seq_step   = STEP_ADDR;
						end else if (w == OPC_REG_RD) begin
							rd_pending = 1'b1;
							seq_step   = STEP_ADDR;
						end else if (w == OPC_BYPASS) begin
							port_bypass = 1'b1;
						end else if (w == OPC_NOP) begin
							seq_step = STEP_IDLE;
						end
					end else if (seq_step == STEP_IDLE) begin
						res.stray_data = 1'b1;
					end else if (seq_step == STEP_ADDR) begin
						reg_addr = w;
						seq_step = STEP_VALUE;
					end else begin
						// value or dummy word closes the access
						if (rd_pending)
							nxt = id_lookup(reg_addr);
						seq_step = STEP_IDLE;
					end
					shift_word = nxt;
				end
			end
			EV_SELECT: begin
				// only a real change of level drops the half word
				if (!ev.sa0_level != port_cmd_mode) begin
					port_cmd_mode = !ev.sa0_level;
					hi_held       = 1'b0;
					hi_byte       = '0;
					if (port_cmd_mode)
						port_bypass = 1'b0;
				end
			end
			EV_RESET: begin
				seq_step    = STEP_IDLE;
				hi_held     = 1'b0;
				hi_byte     = '0;
				shift_word  = '0;
				port_bypass = 1'b0;
			end
			default: ;
		endcase
	endtask

	// Prediction on accepted input, comparison on accepted output
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		out_t pred;
		if (!arst_n) begin
			port_cmd_mode = 1'b0;
			port_bypass   = 1'b0;
			hi_held       = 1'b0;
			hi_byte       = '0;
			shift_word    = '0;
			seq_step      = STEP_IDLE;
			rd_pending    = 1'b0;
			reg_addr      = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with nothing outstanding: %h", out_data);
					n_fail++;
				end else begin
					want = pending_results.pop_front();
					n_checked++;
					if (out_data.byte_out !== want.byte_out) begin
						$error("byte_out expected %02h got %02h", want.byte_out,
							out_data.byte_out);
						n_fail++;
					end
					if (out_data.lcd_valid !== want.lcd_valid) begin
						$error("lcd_valid expected %0b got %0b", want.lcd_valid,
							out_data.lcd_valid);
						n_fail++;
					end
					if (out_data.lcd_byte !== want.lcd_byte) begin
						$error("lcd_byte expected %02h got %02h", want.lcd_byte,
							out_data.lcd_byte);
						n_fail++;
					end
					if (out_data.frame_line !== want.frame_line) begin
						$error("frame_line expected %0b got %0b", want.frame_line,
							out_data.frame_line);
						n_fail++;
					end
					if (out_data.stray_data !== want.stray_data) begin
						$error("stray_data expected %0b got %0b", want.stray_data,
							out_data.stray_data);
						n_fail++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_bridge_event(in_data, pred);
				pending_results.push_back(pred);
			end
			// anything still waiting at the end never arrived
			if (end_check && !end_seen) begin
				end_seen = 1'b1;
				if (pending_results.size() != 0) begin
					$error("%0d result transactions never arrived", pending_results.size());
					n_fail++;
				end
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

FILE: verif/tb_spi_display_bridge_command_port_top.sv
module tb_spi_display_bridge_command_port_top;

	timeunit 1ns;
	timeprecision 1ps;

	import sdb_pkg::*;

	localparam logic [1:0] EV_UNUSED      = 2'd3;
	localparam int         RANDOM_EVENTS  = 500;
	localparam int         HOLD_CYCLES    = 80;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         DRAIN_LIMIT    = 5000;
	localparam int         SETTLE_CYCLES  = 10;

	// Receiver stall behaviour, re-drawn at random as the test runs
	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HALF,
		RX_COMB,
		RX_HEAVY
	} rx_mode_e;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  in_valid  = 1'b0;
	in_t   in_data   = '0;
	logic  out_stall = 1'b0;
	logic  in_stall;
	logic  out_valid;
	out_t  out_data;
	logic  end_check = 1'b0;
	logic  hold_req  = 1'b0;
	int    outstanding;
	int    fail_count;
	int    results_checked;

	int       burst_left   = 0;
	int       n_items      = 0;
	int       n_lcd_words  = 0;
	int       n_reg_access = 0;
	int       n_bypass     = 0;
	int       idle_cycles  = 0;
	int       rx_cycle     = 0;
	int       hold_left    = 0;
	logic     hold_taken   = 1'b0;
	rx_mode_e rx_mode      = RX_FREE;

	spi_display_bridge_command_port_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	spi_display_bridge_command_port_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.end_check       (end_check),
		.outstanding     (outstanding),
		.fail_count      (fail_count),
		.results_checked (results_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: one long hold-off on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 0)
			rx_mode <= rx_mode_e'($urandom_range(0, 4));
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			out_stall  <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end else begin
			case (rx_mode)
				RX_FREE:  out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HALF:  out_stall <= 1'($urandom);
				RX_COMB:  out_stall <= (rx_cycle % 8 < 3);
				default:  out_stall <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("spi_display_bridge_command_port_top: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one event, in bursts separated by random gaps
	task automatic offer(input logic [1:0] kind, input logic [7:0] b, input logic lvl,
		input logic [7:0] r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= '{command: kind, byte_in: b, sa0_level: lvl, lcd_reply: r};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		if (kind != EV_UNUSED)
			n_items++;
	endtask

	task automatic xfer(input logic [7:0] b, input logic [7:0] r);
		offer(EV_XFER, b, 1'($urandom), r);
	endtask

	task automatic set_sa0(input logic lvl);
		offer(EV_SELECT, 8'($urandom), lvl, 8'($urandom));
	endtask

	task automatic pulse_reset();
		offer(EV_RESET, 8'($urandom), 1'($urandom), 8'($urandom));
	endtask

	// High byte first; the LCD answer matters only on the low byte
	task automatic send_word(input logic [15:0] w, input logic [7:0] r);
		xfer(w[15:8], 8'($urandom));
		xfer(w[7:0], r);
	endtask

	// Stop offering until every predicted result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [15:0] pick_addr();
		case ($urandom_range(0, 3))
			0:       return ID_ADDR_0;
			1:       return ID_ADDR_1;
			2:       return ID_ADDR_2;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int   waited;
		logic is_read;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: stray word, LCD forwards at the byte extremes, an ID read,
		// bypass, unknown command word, reset pulse mid-word, unknown event
		send_word(16'h5A5A, 8'h00);
		set_sa0(1'b0);
		set_sa0(1'b0);
		send_word(16'h3FF0, 8'hFF);
		send_word(OPC_LCD_DATA, 8'h00);
		send_word(OPC_REG_RD, 8'hFF);
		set_sa0(1'b1);
		send_word(ID_ADDR_1, 8'h00);
		send_word(16'hFFFF, 8'hFF);
		set_sa0(1'b0);
		send_word(OPC_BYPASS, 8'h00);
		set_sa0(1'b1);
		xfer(8'hFF, 8'h00);
		xfer(8'h00, 8'hFF);
		set_sa0(1'b0);
		send_word(16'hFFFF, 8'h5A);
		xfer(8'h40, 8'hA5);
		pulse_reset();
		offer(EV_UNUSED, 8'hFF, 1'b1, 8'hFF);
		send_word(OPC_REG_WR, 8'h00);
		drain_results();

		// random part, mostly well-formed sequences with random content
		while (n_items < RANDOM_EVENTS + 30) begin
			if (!hold_req && n_items > 150)
				hold_req <= 1'b1;
			if (n_items > 320 && n_items < 330)
				drain_results();
			case ($urandom_range(0, 9))
				0, 1: begin
					set_sa0(1'b0);
					send_word({($urandom_range(0, 1) != 0) ? OPC_LCD_CMD[15:12] :
						OPC_LCD_DATA[15:12], 12'($urandom)}, 8'($urandom));
					n_lcd_words++;
				end
				2, 3: begin
					is_read = 1'($urandom);
					set_sa0(1'b0);
					send_word(is_read ? OPC_REG_RD : OPC_REG_WR, 8'($urandom));
					set_sa0(1'b1);
					send_word(pick_addr(), 8'($urandom));
					send_word(16'($urandom), 8'($urandom));
					set_sa0(1'b0);
					send_word(OPC_NOP, 8'($urandom));
					n_reg_access++;
				end
				4, 5: begin
					set_sa0(1'b0);
					send_word(OPC_BYPASS, 8'($urandom));
					set_sa0(1'b1);
					repeat ($urandom_range(1, 8)) xfer(8'($urandom), 8'($urandom));
					set_sa0(1'b0);
					n_bypass++;
				end
				6: begin
					set_sa0(1'b0);
					send_word(16'($urandom), 8'($urandom));
				end
				7: begin
					set_sa0(1'b1);
					send_word(16'($urandom), 8'($urandom));
				end
				8: begin
					// broken sequence: half a word then a select change or reset
					xfer(8'($urandom), 8'($urandom));
					if ($urandom_range(0, 1) != 0)
						set_sa0(1'($urandom));
					else
						pulse_reset();
				end
				default: begin
					offer(2'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
				end
			endcase
		end

		// wind down and let the pipeline settle
		in_valid <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (outstanding != 0 && waited < DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);
		end_check <= 1'b1;
		repeat (2) @(posedge clk);

		$display("Covered %0d events: %0d LCD forwards, %0d register accesses, %0d bypass runs",
			n_items, n_lcd_words, n_reg_access, n_bypass);
		$display("%0d result transactions compared field by field", results_checked);
		if (fail_count == 0)
			$display("spi_display_bridge_command_port_top: match");
		else
			$display("spi_display_bridge_command_port_top: mismatch");
		$finish;
	end

endmodule
